// ===== rtl/piat_pkg.sv =====
// Package: shared types, codes and constants of the process inspection access table.
package piat_pkg;

    localparam int TASK_SLOTS_DEF  = 128;
    localparam int GRANT_SLOTS_DEF = 64;

    localparam logic [2:0] CMD_SET_LEVEL = 3'd0;
    localparam logic [2:0] CMD_SET_FLAGS = 3'd1;
    localparam logic [2:0] CMD_GRANT     = 3'd2;
    localparam logic [2:0] CMD_REVOKE    = 3'd3;
    localparam logic [2:0] CMD_CHECK     = 3'd4;
    localparam logic [2:0] CMD_QUERY     = 3'd5;

    localparam logic [1:0] LVL_STANDARD = 2'd0;
    localparam logic [1:0] LVL_HARDENED = 2'd1;
    localparam logic [1:0] LVL_SYSTEM   = 2'd2;

    localparam logic [2:0] KIND_SIGNAL = 3'd4;

    localparam logic [1:0] DEC_ALLOW = 2'd0;
    localparam logic [1:0] DEC_DENY  = 2'd1;
    localparam logic [1:0] DEC_AUDIT = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // One command word as it travels from the front to the back
    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] pid;
        logic [31:0] target_id;
        logic [1:0]  level;
        logic [31:0] flag_word;
        logic [2:0]  inspect_kind;
        logic        self_check;
        logic        query_cap;
    } cmd_word_t;

    // Result word of one command
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  decision;
        logic [1:0]  protection;
        logic [31:0] flags_out;
        logic        capable;
    } res_word_t;

endpackage

// ===== rtl/process_inspection_access_table_top.sv =====
// Top level of the process inspection access table.
//
// Channel  | Signals                                   | Handshake
// command  | start, busy, command..inspect_kind        | taken when start && !busy
// config   | cfg_valid, cfg_ready, cfg_data            | written when valid && ready
// result   | done, status..audited_total               | one-cycle strobe, no stall
//
// A check that finds no grant scans the grant table and then the task table;
// set level, set flags and query scan only the task table; grant, revoke and a
// granted check scan only the grant table; self checks, checks under override
// and unknown commands scan neither table.
// A two-word queue lets the front take up to two commands while the back works.
// Reset clears the valid bits and counters at once; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module process_inspection_access_table_top #(
    parameter int TASK_SLOTS  = piat_pkg::TASK_SLOTS_DEF,
    parameter int GRANT_SLOTS = piat_pkg::GRANT_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] pid,
    input  logic [31:0] target_id,
    input  logic [1:0]  level,
    input  logic [31:0] flag_word,
    input  logic [2:0]  inspect_kind,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [1:0]  decision,
    output logic [1:0]  protection,
    output logic [31:0] flags_out,
    output logic        capable,
    output logic [31:0] denied_total,
    output logic [31:0] audited_total
);
    import piat_pkg::*;

    logic      q_full, q_valid, q_pop, back_idle;
    cmd_word_t q_word;
    res_word_t res_word;
    logic      override_reg;

    assign busy      = q_full;
    assign cfg_ready = 1'b1;

    // Override register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            override_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            override_reg <= cfg_data;
        end
    end

    piat_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .command      (command),
        .pid          (pid),
        .target_id    (target_id),
        .level        (level),
        .flag_word    (flag_word),
        .inspect_kind (inspect_kind),
        .accept_en    (1'b1),
        .q_full       (q_full),
        .q_valid      (q_valid),
        .q_word       (q_word),
        .q_pop        (q_pop)
    );

    piat_back #(
        .TASK_SLOTS  (TASK_SLOTS),
        .GRANT_SLOTS (GRANT_SLOTS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .debug_override (override_reg),
        .q_valid        (q_valid),
        .q_word         (q_word),
        .q_pop          (q_pop),
        .idle           (back_idle),
        .res_strobe     (done),
        .res_word       (res_word),
        .deny_total     (denied_total),
        .audit_total    (audited_total)
    );

    assign status     = res_word.status;
    assign decision   = res_word.decision;
    assign protection = res_word.protection;
    assign flags_out  = res_word.flags_out;
    assign capable    = res_word.capable;

    // Queue pops only when the back end is idle
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> back_idle)
        else $error("pop while back end busy");
    // A result strobe never repeats in back-to-back cycles
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("double result strobe");
    // Denied count moves only with a deny result
    assert property (@(posedge clk) disable iff (!rst_n)
        (denied_total != $past(denied_total)) |-> (done && decision == DEC_DENY))
        else $error("deny count moved without deny");

endmodule

// ===== rtl/piat_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
module piat_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0]            command,
    input  logic [31:0]           pid,
    input  logic [31:0]           target_id,
    input  logic [1:0]            level,
    input  logic [31:0]           flag_word,
    input  logic [2:0]            inspect_kind,
    input  logic                  accept_en,
    output logic                  q_full,
    output logic                  q_valid,
    output piat_pkg::cmd_word_t   q_word,
    input  logic                  q_pop
);
    import piat_pkg::*;

    // Two-entry queue
    cmd_word_t  mem_reg [2];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_word_t  in_word;
    logic       push;

    assign q_full  = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_word  = mem_reg[rd_ptr_reg];
    assign push    = start && accept_en && !q_full;

    // Classification done at the door
    always_comb
    begin
        in_word.command      = command;
        in_word.pid          = pid;
        in_word.target_id    = target_id;
        in_word.level        = level;
        in_word.flag_word    = flag_word;
        in_word.inspect_kind = inspect_kind;
        in_word.self_check   = (pid == target_id);
        in_word.query_cap    = (pid == 32'd0) || (pid == 32'd1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ===== rtl/piat_back.sv =====
// Back end: scans the task and grant tables slot by slot and executes commands.
module piat_back #(
    parameter int TASK_SLOTS  = piat_pkg::TASK_SLOTS_DEF,
    parameter int GRANT_SLOTS = piat_pkg::GRANT_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                debug_override,
    input  logic                q_valid,
    input  piat_pkg::cmd_word_t q_word,
    output logic                q_pop,
    output logic                idle,
    output logic                res_strobe,
    output piat_pkg::res_word_t res_word,
    output logic [31:0]         deny_total,
    output logic [31:0]         audit_total
);
    import piat_pkg::*;

    localparam int TW = (TASK_SLOTS  > 1) ? $clog2(TASK_SLOTS)  : 1;
    localparam int GW = (GRANT_SLOTS > 1) ? $clog2(GRANT_SLOTS) : 1;
    localparam logic [TW:0] TLAST = (TW+1)'(TASK_SLOTS - 1);
    localparam logic [GW:0] GLAST = (GW+1)'(GRANT_SLOTS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_GSCAN  = 6'b000010,
        S_TSCAN  = 6'b000100,
        S_GWAIT  = 6'b001000,
        S_TWAIT  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    // Memories
    logic [31:0] e_pid_mem   [TASK_SLOTS];
    logic [1:0]  e_lvl_mem   [TASK_SLOTS];
    logic [31:0] e_flags_mem [TASK_SLOTS];
    logic [31:0] g_insp_mem  [GRANT_SLOTS];
    logic [31:0] g_targ_mem  [GRANT_SLOTS];
    logic [TASK_SLOTS-1:0]  e_valid_reg;
    logic [GRANT_SLOTS-1:0] g_valid_reg;

    state_t      state_reg;
    cmd_word_t   cmd_reg;
    logic [TW-1:0] tidx_reg;
    logic [GW-1:0] gidx_reg;
    logic        rd_ok_reg;     // read data of last issued slot present
    logic [TW-1:0] trd_idx_reg;
    logic [GW-1:0] grd_idx_reg;
    logic [31:0] e_pid_rd, e_flags_rd, g_insp_rd, g_targ_rd;
    logic [1:0]  e_lvl_rd;
    logic        hit_found_reg, free_found_reg;
    logic [TW-1:0] t_hit_reg, t_free_reg;
    logic [GW-1:0] g_hit_reg, g_free_reg;
    logic [1:0]  hit_lvl_reg;
    logic [31:0] hit_flags_reg;
    logic        issue_last_reg;
    logic [31:0] deny_reg, audit_reg;
    res_word_t   res_reg;
    res_word_t   res_next;
    logic        strobe_reg;
    logic        grant_hit_reg;
    logic        t_wr_en;
    logic [TW-1:0] t_wr_idx;
    logic [31:0] t_wr_pid, t_wr_flags;
    logic [1:0]  t_wr_lvl;
    logic        g_wr_en;
    logic [GW-1:0] g_wr_idx;

    assign idle        = (state_reg == S_IDLE);
    assign q_pop       = idle && q_valid;
    assign res_strobe  = strobe_reg;
    assign res_word    = res_reg;
    assign deny_total  = deny_reg;
    assign audit_total = audit_reg;

    // Registered memory reads at the scan index
    always_ff @(posedge clk)
    begin
        e_pid_rd   <= e_pid_mem[tidx_reg];
        e_lvl_rd   <= e_lvl_mem[tidx_reg];
        e_flags_rd <= e_flags_mem[tidx_reg];
        g_insp_rd  <= g_insp_mem[gidx_reg];
        g_targ_rd  <= g_targ_mem[gidx_reg];
        if (t_wr_en)
        begin
            e_pid_mem[t_wr_idx]   <= t_wr_pid;
            e_lvl_mem[t_wr_idx]   <= t_wr_lvl;
            e_flags_mem[t_wr_idx] <= t_wr_flags;
        end
        if (g_wr_en)
        begin
            g_insp_mem[g_wr_idx] <= cmd_reg.pid;
            g_targ_mem[g_wr_idx] <= cmd_reg.target_id;
        end
    end

    // Write controls decided at the end of a scan
    logic needs_grant, needs_task;
    always_comb
    begin
        needs_grant = (cmd_reg.command == CMD_GRANT) || (cmd_reg.command == CMD_REVOKE)
                   || ((cmd_reg.command == CMD_CHECK) && !cmd_reg.self_check
                       && !debug_override);
        needs_task  = (cmd_reg.command == CMD_SET_LEVEL) || (cmd_reg.command == CMD_SET_FLAGS)
                   || (cmd_reg.command == CMD_QUERY)
                   || ((cmd_reg.command == CMD_CHECK) && !cmd_reg.self_check
                       && !debug_override);
        t_wr_en    = 1'b0;
        t_wr_idx   = t_hit_reg;
        t_wr_pid   = cmd_reg.pid;
        t_wr_lvl   = cmd_reg.level;
        t_wr_flags = cmd_reg.flag_word;
        if (state_reg == S_DONE)
        begin
            case (cmd_reg.command)
                CMD_SET_LEVEL:
                begin
                    t_wr_en    = hit_found_reg || free_found_reg;
                    t_wr_idx   = hit_found_reg ? t_hit_reg : t_free_reg;
                    t_wr_flags = hit_found_reg ? hit_flags_reg : 32'd0;
                end
                CMD_SET_FLAGS:
                begin
                    t_wr_en  = hit_found_reg || free_found_reg;
                    t_wr_idx = hit_found_reg ? t_hit_reg : t_free_reg;
                    if (!hit_found_reg)
                    begin
                        t_wr_lvl = LVL_STANDARD;
                    end
                    else if (cmd_reg.flag_word[0] && (hit_lvl_reg == LVL_STANDARD))
                    begin
                        t_wr_lvl = LVL_HARDENED;
                    end
                    else
                    begin
                        t_wr_lvl = hit_lvl_reg;
                    end
                end
                default:
                begin
                    t_wr_en = 1'b0;
                end
            endcase
        end
        g_wr_en  = (state_reg == S_DONE) && (cmd_reg.command == CMD_GRANT)
                && !hit_found_reg && free_found_reg;
        g_wr_idx = g_free_reg;
    end

    // Result word of the finished command
    always_comb
    begin
        res_next = '0;
        case (cmd_reg.command)
            CMD_SET_LEVEL, CMD_SET_FLAGS, CMD_GRANT:
            begin
                if (!hit_found_reg && !free_found_reg)
                begin
                    res_next.status = ST_FULL;
                end
            end
            CMD_REVOKE:
            begin
                if (!hit_found_reg)
                begin
                    res_next.status = ST_NOT_FOUND;
                end
            end
            CMD_CHECK:
            begin
                if (cmd_reg.self_check)
                begin
                    res_next.decision = DEC_ALLOW;
                end
                else if (debug_override)
                begin
                    res_next.decision = DEC_AUDIT;
                end
                else if (grant_hit_reg)
                begin
                    res_next.decision = DEC_ALLOW;
                end
                else if (hit_found_reg && (hit_lvl_reg == LVL_SYSTEM))
                begin
                    res_next.decision = DEC_DENY;
                end
                else if (hit_found_reg && (hit_lvl_reg == LVL_HARDENED)
                         && (cmd_reg.inspect_kind != KIND_SIGNAL))
                begin
                    res_next.decision = DEC_DENY;
                end
                else
                begin
                    res_next.decision = DEC_AUDIT;
                end
            end
            CMD_QUERY:
            begin
                if (hit_found_reg)
                begin
                    res_next.protection = hit_lvl_reg;
                    res_next.flags_out  = hit_flags_reg;
                end
                res_next.capable = cmd_reg.query_cap || debug_override;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // Match tests on the registered read data
    logic g_match, t_match;
    assign g_match = g_valid_reg[grd_idx_reg] && (g_insp_rd == cmd_reg.pid)
                  && (g_targ_rd == cmd_reg.target_id);
    assign t_match = e_valid_reg[trd_idx_reg] && (e_pid_rd ==
                     ((cmd_reg.command == CMD_CHECK) ? cmd_reg.target_id : cmd_reg.pid));

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            e_valid_reg    <= '0;
            g_valid_reg    <= '0;
            deny_reg       <= '0;
            audit_reg      <= '0;
            strobe_reg     <= 1'b0;
            tidx_reg       <= '0;
            gidx_reg       <= '0;
            rd_ok_reg      <= 1'b0;
            issue_last_reg <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= (state_reg == S_DONE);
            case (state_reg)
                S_IDLE:
                begin
                    rd_ok_reg      <= 1'b0;
                    issue_last_reg <= 1'b0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    tidx_reg       <= '0;
                    gidx_reg       <= '0;
                    if (q_valid)
                    begin
                        cmd_reg   <= q_word;
                        state_reg <= S_GSCAN;
                    end
                end
                S_GSCAN:
                begin
                    if (!needs_grant)
                    begin
                        state_reg <= needs_task ? S_TSCAN : S_DONE;
                        rd_ok_reg <= 1'b0;
                        issue_last_reg <= 1'b0;
                    end
                    else
                    begin
                        // collect result of previously issued slot
                        if (rd_ok_reg)
                        begin
                            if (g_match && !hit_found_reg)
                            begin
                                hit_found_reg <= 1'b1;
                                g_hit_reg     <= grd_idx_reg;
                            end
                            if (!g_valid_reg[grd_idx_reg] && !free_found_reg)
                            begin
                                free_found_reg <= 1'b1;
                                g_free_reg     <= grd_idx_reg;
                            end
                        end
                        grd_idx_reg <= gidx_reg;
                        rd_ok_reg   <= 1'b1;
                        if ({1'b0, gidx_reg} == GLAST)
                        begin
                            state_reg <= S_GWAIT;
                        end
                        else
                        begin
                            gidx_reg <= gidx_reg + 1'b1;
                        end
                    end
                end
                S_GWAIT:
                begin
                    rd_ok_reg <= 1'b0;
                    // a check with a grant needs no task scan
                    if ((cmd_reg.command == CMD_CHECK)
                        && !(g_match || hit_found_reg))
                    begin
                        state_reg      <= S_TSCAN;
                        free_found_reg <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                        if (g_match && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            g_hit_reg     <= grd_idx_reg;
                        end
                        if (!g_valid_reg[grd_idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            g_free_reg     <= grd_idx_reg;
                        end
                    end
                end
                S_TSCAN:
                begin
                    if (rd_ok_reg)
                    begin
                        if (t_match && !hit_found_reg)
                        begin
                            hit_found_reg <= 1'b1;
                            t_hit_reg     <= trd_idx_reg;
                            hit_lvl_reg   <= e_lvl_rd;
                            hit_flags_reg <= e_flags_rd;
                        end
                        if (!e_valid_reg[trd_idx_reg] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            t_free_reg     <= trd_idx_reg;
                        end
                    end
                    trd_idx_reg <= tidx_reg;
                    rd_ok_reg   <= 1'b1;
                    if ({1'b0, tidx_reg} == TLAST)
                    begin
                        state_reg <= S_TWAIT;
                    end
                    else
                    begin
                        tidx_reg <= tidx_reg + 1'b1;
                    end
                end
                S_TWAIT:
                begin
                    if (t_match && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        t_hit_reg     <= trd_idx_reg;
                        hit_lvl_reg   <= e_lvl_rd;
                        hit_flags_reg <= e_flags_rd;
                    end
                    if (!e_valid_reg[trd_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        t_free_reg     <= trd_idx_reg;
                    end
                    rd_ok_reg <= 1'b0;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    res_reg   <= res_next;
                    state_reg <= S_IDLE;
                    if ((cmd_reg.command == CMD_CHECK) && (res_next.decision == DEC_DENY))
                    begin
                        deny_reg <= deny_reg + 32'd1;
                    end
                    if ((cmd_reg.command == CMD_CHECK) && (res_next.decision == DEC_AUDIT))
                    begin
                        audit_reg <= audit_reg + 32'd1;
                    end
                    case (cmd_reg.command)
                        CMD_SET_LEVEL, CMD_SET_FLAGS:
                        begin
                            if (hit_found_reg)
                            begin
                                e_valid_reg[t_hit_reg] <= 1'b1;
                            end
                            else if (free_found_reg)
                            begin
                                e_valid_reg[t_free_reg] <= 1'b1;
                            end
                        end
                        CMD_GRANT:
                        begin
                            if (!hit_found_reg && free_found_reg)
                            begin
                                g_valid_reg[g_free_reg] <= 1'b1;
                            end
                        end
                        CMD_REVOKE:
                        begin
                            if (hit_found_reg)
                            begin
                                g_valid_reg[g_hit_reg] <= 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Marks a grant hit at the end of the grant scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_hit_reg <= 1'b0;
        end
        else if (state_reg == S_IDLE)
        begin
            grant_hit_reg <= 1'b0;
        end
        else if ((state_reg == S_GWAIT) && (g_match || hit_found_reg))
        begin
            grant_hit_reg <= 1'b1;
        end
    end

endmodule

// ===== tb/tb_process_inspection_access_table_top.sv =====
// Testbench of the process inspection access table: directed and random commands checked against a predictor.
module tb_process_inspection_access_table_top;
    timeunit 1ns;
    timeprecision 1ps;
    import piat_pkg::*;

    localparam int NUM_TASKS  = 128;
    localparam int NUM_GRANTS = 64;
    localparam int CYCLE_LIMIT = 1200000;
    localparam int SCAN_CYCLES = 220;

    // one expected result word
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  decision;
        logic [1:0]  protection;
        logic [31:0] flags_out;
        logic        capable;
        logic [31:0] denied_total;
        logic [31:0] audited_total;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  command;
    logic [31:0] pid;
    logic [31:0] target_id;
    logic [1:0]  level;
    logic [31:0] flag_word;
    logic [2:0]  inspect_kind;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [1:0]  decision;
    logic [1:0]  protection;
    logic [31:0] flags_out;
    logic        capable;
    logic [31:0] denied_total;
    logic [31:0] audited_total;

    process_inspection_access_table_top DUT (.*);

    // predictor copy of the tables
    logic [31:0] proc_id    [NUM_TASKS];
    logic [1:0]  proc_level [NUM_TASKS];
    logic [31:0] proc_flags [NUM_TASKS];
    logic        proc_used  [NUM_TASKS];
    logic [31:0] grant_from [NUM_GRANTS];
    logic [31:0] grant_to   [NUM_GRANTS];
    logic        grant_used [NUM_GRANTS];
    logic [31:0] deny_count;
    logic [31:0] audit_count;
    logic        override_on;

    verdict_t pending_verdicts[$];
    int       errors;
    int       cycles;
    int       sent;
    bit       gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int find_proc(logic [31:0] id);
        for (int i = 0; i < NUM_TASKS; i++)
            if (proc_used[i] && proc_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic int free_proc();
        for (int i = 0; i < NUM_TASKS; i++)
            if (!proc_used[i])
                return i;
        return -1;
    endfunction

    function automatic int find_grant(logic [31:0] a, logic [31:0] b);
        for (int i = 0; i < NUM_GRANTS; i++)
            if (grant_used[i] && grant_from[i] == a && grant_to[i] == b)
                return i;
        return -1;
    endfunction

    // apply one command to the predicted tables and return the expected word
    function automatic verdict_t predict_command(logic [2:0] cmd, logic [31:0] p,
            logic [31:0] t, logic [1:0] lv, logic [31:0] fw, logic [2:0] kind);
        verdict_t v;
        int e;
        int f;
        logic [1:0] tl;
        v = '0;
        case (cmd)
            CMD_SET_LEVEL, CMD_SET_FLAGS:
            begin
                e = find_proc(p);
                if (e >= 0)
                begin
                    if (cmd == CMD_SET_LEVEL)
                        proc_level[e] = lv;
                    else
                    begin
                        proc_flags[e] = fw;
                        if (fw[0] && proc_level[e] == LVL_STANDARD)
                            proc_level[e] = LVL_HARDENED;
                    end
                end
                else
                begin
                    f = free_proc();
                    if (f < 0)
                        v.status = ST_FULL;
                    else
                    begin
                        proc_id[f] = p;
                        proc_used[f] = 1'b1;
                        proc_level[f] = (cmd == CMD_SET_LEVEL) ? lv : LVL_STANDARD;
                        proc_flags[f] = (cmd == CMD_SET_LEVEL) ? 32'd0 : fw;
                    end
                end
            end
            CMD_GRANT:
            begin
                if (find_grant(p, t) < 0)
                begin
                    v.status = ST_FULL;
                    for (int i = 0; i < NUM_GRANTS; i++)
                        if (!grant_used[i])
                        begin
                            grant_from[i] = p;
                            grant_to[i] = t;
                            grant_used[i] = 1'b1;
                            v.status = ST_OK;
                            break;
                        end
                end
            end
            CMD_REVOKE:
            begin
                e = find_grant(p, t);
                if (e >= 0)
                    grant_used[e] = 1'b0;
                else
                    v.status = ST_NOT_FOUND;
            end
            CMD_CHECK:
            begin
                if (p == t)
                    v.decision = DEC_ALLOW;
                else if (override_on)
                    v.decision = DEC_AUDIT;
                else if (find_grant(p, t) >= 0)
                    v.decision = DEC_ALLOW;
                else
                begin
                    e = find_proc(t);
                    tl = (e >= 0) ? proc_level[e] : LVL_STANDARD;
                    if (tl == LVL_SYSTEM)
                        v.decision = DEC_DENY;
                    else if (tl == LVL_HARDENED)
                        v.decision = (kind == KIND_SIGNAL) ? DEC_AUDIT : DEC_DENY;
                    else
                        v.decision = DEC_AUDIT;
                end
                if (p != t && v.decision == DEC_DENY)
                    deny_count = deny_count + 1;
                if (p != t && v.decision == DEC_AUDIT)
                    audit_count = audit_count + 1;
            end
            CMD_QUERY:
            begin
                e = find_proc(p);
                if (e >= 0)
                begin
                    v.protection = proc_level[e];
                    v.flags_out = proc_flags[e];
                end
                v.capable = (p == 0 || p == 1 || override_on);
            end
            default: ;
        endcase
        v.denied_total = deny_count;
        v.audited_total = audit_count;
        return v;
    endfunction

    // result checker: every strobe is compared with the oldest expectation
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t got;
        if (rst_n && done)
        begin
            got = '{status, decision, protection, flags_out, capable,
                    denied_total, audited_total};
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                if (got.decision !== want.decision)
                    $display("%0t: decision exp %0d got %0d", $time, want.decision,
                             got.decision);
                if (got.protection !== want.protection)
                    $display("%0t: protection exp %0d got %0d", $time, want.protection,
                             got.protection);
                if (got.flags_out !== want.flags_out)
                    $display("%0t: flags_out exp %h got %h", $time, want.flags_out,
                             got.flags_out);
                if (got.capable !== want.capable)
                    $display("%0t: capable exp %0d got %0d", $time, want.capable,
                             got.capable);
                if (got.denied_total !== want.denied_total)
                    $display("%0t: denied_total exp %0d got %0d", $time,
                             want.denied_total, got.denied_total);
                if (got.audited_total !== want.audited_total)
                    $display("%0t: audited_total exp %0d got %0d", $time,
                             want.audited_total, got.audited_total);
                if (got !== want)
                    errors++;
            end
        end
    end

    // send one command word, waiting for the block to take it; start stays
    // high after the accept until the next word or an idle burst replaces it
    task automatic send_command(logic [2:0] cmd, logic [31:0] p, logic [31:0] t,
            logic [1:0] lv, logic [31:0] fw, logic [2:0] kind);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        pid <= p;
        target_id <= t;
        level <= lv;
        flag_word <= fw;
        inspect_kind <= kind;
        do
            @(posedge clk);
        while (busy);
        pending_verdicts.push_back(predict_command(cmd, p, t, lv, fw, kind));
        sent++;
        @(negedge clk);
    endtask

    // wait until all results are back, then write the override register
    task automatic set_override(logic value);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        override_on = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // directed: every command, levels, self check, hardened upgrade rules
    task automatic test_directed();
        send_command(CMD_QUERY, 32'd0, 0, 0, 0, 0);
        send_command(CMD_QUERY, 32'd1, 0, 0, 0, 0);
        send_command(CMD_SET_FLAGS, 32'd10, 0, 0, 32'h1, 0);   // new entry: no upgrade
        send_command(CMD_QUERY, 32'd10, 0, 0, 0, 0);
        send_command(CMD_SET_FLAGS, 32'd10, 0, 0, 32'hFFFF_FFFF, 0); // existing: upgrade
        send_command(CMD_QUERY, 32'd10, 0, 0, 0, 0);
        send_command(CMD_SET_LEVEL, 32'hFFFF_FFFF, 0, LVL_SYSTEM, 0, 0);
        send_command(CMD_SET_LEVEL, 32'd20, 0, 2'd3, 0, 0);
        send_command(CMD_SET_FLAGS, 32'd20, 0, 0, 32'h1, 0);   // level three stays
        send_command(CMD_QUERY, 32'd20, 0, 0, 0, 0);
        send_command(CMD_CHECK, 32'd5, 32'd5, 0, 0, 3'd0);     // self
        send_command(CMD_CHECK, 32'd5, 32'hFFFF_FFFF, 0, 0, 3'd2);
        send_command(CMD_CHECK, 32'd5, 32'd10, 0, 0, KIND_SIGNAL);
        send_command(CMD_CHECK, 32'd5, 32'd10, 0, 0, 3'd7);
        send_command(CMD_CHECK, 32'd5, 32'd20, 0, 0, 3'd1);
        send_command(CMD_CHECK, 32'd5, 32'd99, 0, 0, 3'd3);    // absent target
        send_command(CMD_GRANT, 32'd5, 32'hFFFF_FFFF, 0, 0, 0);
        send_command(CMD_GRANT, 32'd5, 32'hFFFF_FFFF, 0, 0, 0);
        send_command(CMD_CHECK, 32'd5, 32'hFFFF_FFFF, 0, 0, 3'd6);
        send_command(CMD_REVOKE, 32'd5, 32'hFFFF_FFFF, 0, 0, 0);
        send_command(CMD_REVOKE, 32'd5, 32'hFFFF_FFFF, 0, 0, 0);
        send_command(3'd6, 32'd1, 32'd2, 2'd3, 32'hFFFF_FFFF, 3'd7);
        send_command(3'd7, 32'd1, 32'd2, 2'd1, 32'h0, 3'd5);
    endtask

    // override on: non-self checks audited, queries capable
    task automatic test_override();
        set_override(1'b1);
        send_command(CMD_CHECK, 32'd5, 32'hFFFF_FFFF, 0, 0, 3'd0);
        send_command(CMD_CHECK, 32'd7, 32'd7, 0, 0, 3'd0);
        send_command(CMD_QUERY, 32'h1234_5678, 0, 0, 0, 0);
        set_override(1'b0);
    endtask

    // fill both tables to their limits, then overflow and free
    task automatic test_table_full();
        for (int i = 0; i < NUM_TASKS + 2; i++)
            send_command(CMD_SET_LEVEL, 32'h8000_0000 + i, 0, 2'(i % 3), 0, 0);
        send_command(CMD_SET_FLAGS, 32'h7000_0000, 0, 0, 32'h5, 0);
        for (int i = 0; i < NUM_GRANTS + 2; i++)
            send_command(CMD_GRANT, 32'd3, 32'h9000_0000 + i, 0, 0, 0);
        send_command(CMD_REVOKE, 32'd3, 32'h9000_0005, 0, 0, 0);
        send_command(CMD_GRANT, 32'd4, 32'd4, 0, 0, 0);
        send_command(CMD_CHECK, 32'd3, 32'h8000_0002, 0, 0, 0);
        for (int i = 0; i < NUM_GRANTS; i++)
            send_command(CMD_REVOKE, (i == 5) ? 32'd4 : 32'd3,
                         (i == 5) ? 32'd4 : 32'h9000_0000 + i, 0, 0, 0);
    endtask

    // random commands over a small id pool, with full-range noise mixed in
    task automatic test_random(int count);
        logic [31:0] p;
        logic [31:0] t;
        for (int n = 0; n < count; n++)
        begin
            gaps_on = (n < count - 150);
            if ($urandom_range(0, 9) == 0)
                p = $urandom();
            else
                p = 32'h8000_0000 + $urandom_range(0, 140);
            if ($urandom_range(0, 9) == 0)
                t = $urandom();
            else
                t = 32'h8000_0000 + $urandom_range(0, 140);
            if (n == count / 2)
                set_override(1'b1);
            if (n == count / 2 + 100)
                set_override(1'b0);
            send_command(($urandom_range(0, 30) == 0) ? 3'($urandom_range(6, 7))
                                                      : 3'($urandom_range(0, 5)),
                         p, t, 2'($urandom_range(0, 3)), $urandom(),
                         3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        pid = '0;
        target_id = '0;
        level = '0;
        flag_word = '0;
        inspect_kind = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        errors = 0;
        cycles = 0;
        sent = 0;
        gaps_on = 1'b1;
        deny_count = '0;
        audit_count = '0;
        override_on = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++)
            proc_used[i] = 1'b0;
        for (int i = 0; i < NUM_GRANTS; i++)
            grant_used[i] = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        set_override(1'b0);
        test_directed();
        test_override();
        test_table_full();
        test_random(910);
        start <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (SCAN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
